// ----- rtl/ptr_pkg.sv -----
package ptr_pkg;

  // Ring depth and derived widths.
  localparam int unsigned History  = 16;
  localparam int unsigned IdxW     = $clog2(History);
  localparam int unsigned FillW    = $clog2(History + 1);

  // Item field widths.
  localparam int unsigned PresW    = 17;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned RateW    = 32;
  localparam int unsigned ClassW   = 2;
  localparam int unsigned HeldW    = 5;
  localparam int unsigned ThrW     = 16;
  localparam logic [ThrW-1:0] ThrReset = 16'd50;

  // Widths of the regression sums.
  localparam int unsigned SxW      = TimeW + IdxW;
  localparam int unsigned SyW      = PresW + IdxW;
  localparam int unsigned SxyW     = TimeW + PresW + IdxW;
  localparam int unsigned SxxW     = 2 * TimeW + IdxW;

  // Pa/ms to Pa/hour scale factor.
  localparam int unsigned ScaleW   = 22;
  localparam logic [ScaleW-1:0] Scale = 22'd3600000;

  // Datapath width of the shared unit: holds the scaled numerator.
  localparam int unsigned NumW     = SxyW + FillW;
  localparam int unsigned AluW     = NumW + ScaleW;
  localparam int unsigned CntW     = $clog2(AluW + 1);

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_e;

  typedef enum logic [ClassW-1:0] {
    CLS_UNKNOWN = 2'd0,
    CLS_RISING  = 2'd1,
    CLS_FALLING = 2'd2,
    CLS_STABLE  = 2'd3
  } trend_class_e;

  typedef struct packed {
    logic              start;
    alu_op_e           op;
    logic [AluW-1:0]   acc;
    logic [AluW-1:0]   a;
    logic [AluW-1:0]   b;
    logic [CntW-1:0]   cnt;
  } alu_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [AluW-1:0]   acc;
    logic [AluW-1:0]   b;
  } alu_rsp_t;

endpackage

// ----- rtl/ptr_if.sv -----
interface ptr_in_if;
  logic                              valid;
  logic                              ready;
  logic [ptr_pkg::PresW-1:0]         pressure_pa;
  logic [ptr_pkg::TimeW-1:0]         time_ms;

  modport source (output valid, output pressure_pa, output time_ms, input ready);
  modport sink   (input valid, input pressure_pa, input time_ms, output ready);
endinterface

interface ptr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ptr_pkg::RateW-1:0]  rate_pa_per_hour;
  logic [ptr_pkg::ClassW-1:0]        trend_class;
  logic [ptr_pkg::HeldW-1:0]         samples_held;

  modport source (output valid, output rate_pa_per_hour, output trend_class,
                  output samples_held, input ready);
  modport sink   (input valid, input rate_pa_per_hour, input trend_class,
                  input samples_held, output ready);
endinterface

// ----- rtl/ptr_alu.sv -----
// Shared shift-add multiplier and restoring divider around one wide adder.
module ptr_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptr_pkg::alu_req_t req_i,
  output ptr_pkg::alu_rsp_t rsp_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  ptr_pkg::alu_op_e             op_q, op_d;
  logic [ptr_pkg::AluW-1:0]     acc_q, acc_d;
  logic [ptr_pkg::AluW-1:0]     a_q, a_d;
  logic [ptr_pkg::AluW-1:0]     b_q, b_d;
  logic [ptr_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic                         sub;
  logic [ptr_pkg::AluW-1:0]     lhs;
  logic [ptr_pkg::AluW:0]       sum;

  always_comb begin
    sub = (op_q == ptr_pkg::ALU_DIV);
    lhs = sub ? {acc_q[ptr_pkg::AluW-2:0], b_q[ptr_pkg::AluW-1]} : acc_q;
    // In divide mode the carry out is set when the remainder covers the divisor.
    sum = {1'b0, lhs} + {1'b0, (sub ? ~a_q : a_q)} + {{ptr_pkg::AluW{1'b0}}, sub};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      acc_d  = req_i.acc;
      a_d    = req_i.a;
      b_d    = req_i.b;
      cnt_d  = req_i.cnt;
    end else if (busy_q) begin
      if (sub) begin
        acc_d = sum[ptr_pkg::AluW] ? sum[ptr_pkg::AluW-1:0] : lhs;
        b_d   = {b_q[ptr_pkg::AluW-2:0], sum[ptr_pkg::AluW]};
      end else begin
        acc_d = b_q[0] ? sum[ptr_pkg::AluW-1:0] : acc_q;
        a_d   = {a_q[ptr_pkg::AluW-2:0], 1'b0};
        b_d   = {1'b0, b_q[ptr_pkg::AluW-1:1]};
      end
      cnt_d = cnt_q - ptr_pkg::CntW'(1);
      if (cnt_q == ptr_pkg::CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ptr_pkg::ALU_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.acc  = acc_q;
  assign rsp_o.b    = b_q;

endmodule

// ----- rtl/pressure_trend_regression.sv -----
// Channel  Dir  Handshake      Payload
// in_i     in   valid/ready    pressure_pa[16:0], time_ms[31:0]
// out_o    out  valid/ready    rate_pa_per_hour[31:0] signed, trend_class[1:0],
//                              samples_held[4:0]
// cfg      in   cfg_we_i       cfg_wdata_i[15:0] = trend threshold in Pa/hour
//
// An item with two or more held samples runs through the shared shift-add
// multiplier and divider, which retires one operand bit per cycle and does all
// products and the 80-bit division; with fewer than two samples the item goes
// straight to the finish state.
// Reset clears the write slot, the fill level, the state and the output valid,
// and loads the threshold with 50. The ring memories are not cleared.
// Input ready is high only in the idle state. The finished result sits in an
// output register; a new item is accepted while it still waits to be taken.
module pressure_trend_regression (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  ptr_in_if.sink                    in_i,
  ptr_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic [ptr_pkg::ThrW-1:0]  cfg_wdata_i
);

  // One-hot sequencer states.
  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_T0     = 14'b00000000000010,
    S_T0W    = 14'b00000000000100,
    S_FETCH  = 14'b00000000001000,
    S_LOAD   = 14'b00000000010000,
    S_MXX    = 14'b00000000100000,
    S_MXY    = 14'b00000001000000,
    S_NSXX   = 14'b00000010000000,
    S_SXSX   = 14'b00000100000000,
    S_NSXY   = 14'b00001000000000,
    S_SXSY   = 14'b00010000000000,
    S_SCALE  = 14'b00100000000000,
    S_DIVIDE = 14'b01000000000000,
    S_FINISH = 14'b10000000000000
  } state_e;

  state_e                          state_q, state_d;

  // Sample ring: two memories written on accept and read one entry per cycle.
  logic [ptr_pkg::PresW-1:0]       pres_mem [ptr_pkg::History];
  logic [ptr_pkg::TimeW-1:0]       time_mem [ptr_pkg::History];
  logic [ptr_pkg::PresW-1:0]       pres_rd_q;
  logic [ptr_pkg::TimeW-1:0]       time_rd_q;
  logic [ptr_pkg::IdxW-1:0]        rd_addr;

  logic [ptr_pkg::IdxW-1:0]        slot_q, slot_d;
  logic [ptr_pkg::FillW-1:0]       fill_q, fill_d;
  logic [ptr_pkg::IdxW-1:0]        base_q, base_d;
  logic [ptr_pkg::IdxW-1:0]        idx_q, idx_d;
  logic [ptr_pkg::ThrW-1:0]        thr_q;

  // Regression sums and intermediates.
  logic [ptr_pkg::TimeW-1:0]       t0_q, t0_d;
  logic [ptr_pkg::TimeW-1:0]       x_q, x_d;
  logic [ptr_pkg::PresW-1:0]       y_q, y_d;
  logic [ptr_pkg::SxW-1:0]         sx_q, sx_d;
  logic [ptr_pkg::SyW-1:0]         sy_q, sy_d;
  logic [ptr_pkg::SxyW-1:0]        sxy_q, sxy_d;
  logic [ptr_pkg::SxxW-1:0]        sxx_q, sxx_d;
  logic [ptr_pkg::AluW-1:0]        tmp_q, tmp_d;
  logic [ptr_pkg::AluW-1:0]        den_q, den_d;
  logic                            neg_q, neg_d;

  logic [ptr_pkg::RateW-1:0]       res_rate_q, res_rate_d;
  ptr_pkg::trend_class_e           res_cls_q, res_cls_d;

  logic                            out_valid_q, out_valid_d;
  logic [ptr_pkg::RateW-1:0]       out_rate_q, out_rate_d;
  ptr_pkg::trend_class_e           out_cls_q, out_cls_d;
  logic [ptr_pkg::FillW-1:0]       out_held_q, out_held_d;

  ptr_pkg::alu_req_t               alu_req;
  ptr_pkg::alu_rsp_t               alu_rsp;

  logic                            in_acc;
  logic [ptr_pkg::IdxW:0]          idx_sum;
  logic [ptr_pkg::TimeW-1:0]       x_new;
  logic [ptr_pkg::AluW-1:0]        diff_ab;
  logic [ptr_pkg::AluW-1:0]        diff_ba;
  logic [ptr_pkg::AluW-1:0]        quo;
  logic [ptr_pkg::RateW-1:0]       rate_sat;
  logic signed [ptr_pkg::RateW:0]  rate_ext;
  logic signed [ptr_pkg::RateW:0]  thr_pos;
  logic signed [ptr_pkg::RateW:0]  thr_neg;
  logic                            out_free;

  ptr_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_o.ready;

  // Ring index of the current sample, wrapping at the ring depth.
  assign idx_sum = {1'b0, base_q} + {1'b0, idx_q};
  always_comb begin
    if (idx_sum >= (ptr_pkg::IdxW + 1)'(ptr_pkg::History)) begin
      rd_addr = ptr_pkg::IdxW'(idx_sum - (ptr_pkg::IdxW + 1)'(ptr_pkg::History));
    end else begin
      rd_addr = idx_sum[ptr_pkg::IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pres_mem[slot_q] <= in_i.pressure_pa;
      time_mem[slot_q] <= in_i.time_ms;
    end
    pres_rd_q <= pres_mem[rd_addr];
    time_rd_q <= time_mem[rd_addr];
  end

  assign x_new = time_rd_q - t0_q;

  // Both orders of the numerator difference; the sign picks one.
  assign diff_ab = tmp_q - alu_rsp.acc;
  assign diff_ba = alu_rsp.acc - tmp_q;

  // Saturate the magnitude quotient to the signed 32-bit range.
  assign quo = alu_rsp.b;
  always_comb begin
    if (neg_q) begin
      if ((|quo[ptr_pkg::AluW-1:ptr_pkg::RateW]) ||
          (quo[ptr_pkg::RateW-1] && (|quo[ptr_pkg::RateW-2:0]))) begin
        rate_sat = {1'b1, {(ptr_pkg::RateW-1){1'b0}}};
      end else begin
        rate_sat = ptr_pkg::RateW'(0) - quo[ptr_pkg::RateW-1:0];
      end
    end else begin
      if (|quo[ptr_pkg::AluW-1:ptr_pkg::RateW-1]) begin
        rate_sat = {1'b0, {(ptr_pkg::RateW-1){1'b1}}};
      end else begin
        rate_sat = quo[ptr_pkg::RateW-1:0];
      end
    end
  end

  assign rate_ext = $signed({rate_sat[ptr_pkg::RateW-1], rate_sat});
  assign thr_pos  = $signed({{(ptr_pkg::RateW + 1 - ptr_pkg::ThrW){1'b0}}, thr_q});
  assign thr_neg  = -thr_pos;

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    fill_d      = fill_q;
    base_d      = base_q;
    idx_d       = idx_q;
    t0_d        = t0_q;
    x_d         = x_q;
    y_d         = y_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    sxy_d       = sxy_q;
    sxx_d       = sxx_q;
    tmp_d       = tmp_q;
    den_d       = den_q;
    neg_d       = neg_q;
    res_rate_d  = res_rate_q;
    res_cls_d   = res_cls_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_rate_d  = out_rate_q;
    out_cls_d   = out_cls_q;
    out_held_d  = out_held_q;
    alu_req     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (slot_q == ptr_pkg::IdxW'(ptr_pkg::History - 1)) begin
            slot_d = '0;
          end else begin
            slot_d = slot_q + ptr_pkg::IdxW'(1);
          end
          if (fill_q < ptr_pkg::FillW'(ptr_pkg::History)) begin
            fill_d = fill_q + ptr_pkg::FillW'(1);
          end
          // The oldest sample sits at slot 0 until the ring is full.
          base_d = (fill_d < ptr_pkg::FillW'(ptr_pkg::History)) ? '0 : slot_d;
          idx_d  = '0;
          sx_d   = '0;
          sy_d   = '0;
          sxy_d  = '0;
          sxx_d  = '0;
          if (fill_d < ptr_pkg::FillW'(2)) begin
            res_rate_d = '0;
            res_cls_d  = ptr_pkg::CLS_UNKNOWN;
            state_d    = S_FINISH;
          end else begin
            state_d = S_T0;
          end
        end
      end
      S_T0: begin
        state_d = S_T0W;
      end
      S_T0W: begin
        t0_d    = time_rd_q;
        state_d = S_FETCH;
      end
      S_FETCH: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        x_d  = x_new;
        y_d  = pres_rd_q;
        sx_d = sx_q + ptr_pkg::SxW'(x_new);
        sy_d = sy_q + ptr_pkg::SyW'(pres_rd_q);
        alu_req.start = 1'b1;
        alu_req.op    = ptr_pkg::ALU_MUL;
        alu_req.acc   = ptr_pkg::AluW'(sxx_q);
        alu_req.a     = ptr_pkg::AluW'(x_new);
        alu_req.b     = ptr_pkg::AluW'(x_new);
        alu_req.cnt   = ptr_pkg::CntW'(ptr_pkg::TimeW);
        state_d = S_MXX;
      end
      S_MXX: begin
        if (alu_rsp.done) begin
          sxx_d = alu_rsp.acc[ptr_pkg::SxxW-1:0];
          alu_req.start = 1'b1;
          alu_req.op    = ptr_pkg::ALU_MUL;
          alu_req.acc   = ptr_pkg::AluW'(sxy_q);
          alu_req.a     = ptr_pkg::AluW'(x_q);
          alu_req.b     = ptr_pkg::AluW'(y_q);
          alu_req.cnt   = ptr_pkg::CntW'(ptr_pkg::PresW);
          state_d = S_MXY;
        end
      end
      S_MXY: begin
        if (alu_rsp.done) begin
          sxy_d = alu_rsp.acc[ptr_pkg::SxyW-1:0];
          if ((ptr_pkg::FillW'(idx_q) + ptr_pkg::FillW'(1)) == fill_q) begin
            // All samples summed: form n*Sxx first.
            alu_req.start = 1'b1;
            alu_req.op    = ptr_pkg::ALU_MUL;
            alu_req.acc   = '0;
            alu_req.a     = ptr_pkg::AluW'(sxx_q);
            alu_req.b     = ptr_pkg::AluW'(fill_q);
            alu_req.cnt   = ptr_pkg::CntW'(ptr_pkg::FillW);
            state_d = S_NSXX;
          end else begin
            idx_d   = idx_q + ptr_pkg::IdxW'(1);
            state_d = S_FETCH;
          end
        end
      end
      S_NSXX: begin
        if (alu_rsp.done) begin
          tmp_d = alu_rsp.acc;
          alu_req.start = 1'b1;
          alu_req.op    = ptr_pkg::ALU_MUL;
          alu_req.acc   = '0;
          alu_req.a     = ptr_pkg::AluW'(sx_q);
          alu_req.b     = ptr_pkg::AluW'(sx_q);
          alu_req.cnt   = ptr_pkg::CntW'(ptr_pkg::SxW);
          state_d = S_SXSX;
        end
      end
      S_SXSX: begin
        if (alu_rsp.done) begin
          den_d = diff_ab;
          if (diff_ab == '0) begin
            // All timestamps equal: no slope, reported as stable.
            res_rate_d = '0;
            res_cls_d  = ptr_pkg::CLS_STABLE;
            state_d    = S_FINISH;
          end else begin
            alu_req.start = 1'b1;
            alu_req.op    = ptr_pkg::ALU_MUL;
            alu_req.acc   = '0;
            alu_req.a     = ptr_pkg::AluW'(sxy_q);
            alu_req.b     = ptr_pkg::AluW'(fill_q);
            alu_req.cnt   = ptr_pkg::CntW'(ptr_pkg::FillW);
            state_d = S_NSXY;
          end
        end
      end
      S_NSXY: begin
        if (alu_rsp.done) begin
          tmp_d = alu_rsp.acc;
          alu_req.start = 1'b1;
          alu_req.op    = ptr_pkg::ALU_MUL;
          alu_req.acc   = '0;
          alu_req.a     = ptr_pkg::AluW'(sx_q);
          alu_req.b     = ptr_pkg::AluW'(sy_q);
          alu_req.cnt   = ptr_pkg::CntW'(ptr_pkg::SyW);
          state_d = S_SXSY;
        end
      end
      S_SXSY: begin
        if (alu_rsp.done) begin
          neg_d = (tmp_q < alu_rsp.acc);
          alu_req.start = 1'b1;
          alu_req.op    = ptr_pkg::ALU_MUL;
          alu_req.acc   = '0;
          alu_req.a     = (tmp_q < alu_rsp.acc) ? diff_ba : diff_ab;
          alu_req.b     = ptr_pkg::AluW'(ptr_pkg::Scale);
          alu_req.cnt   = ptr_pkg::CntW'(ptr_pkg::ScaleW);
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        if (alu_rsp.done) begin
          alu_req.start = 1'b1;
          alu_req.op    = ptr_pkg::ALU_DIV;
          alu_req.acc   = '0;
          alu_req.a     = den_q;
          alu_req.b     = alu_rsp.acc;
          alu_req.cnt   = ptr_pkg::CntW'(ptr_pkg::AluW);
          state_d = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (alu_rsp.done) begin
          res_rate_d = rate_sat;
          if (rate_ext > thr_pos) begin
            res_cls_d = ptr_pkg::CLS_RISING;
          end else if (rate_ext < thr_neg) begin
            res_cls_d = ptr_pkg::CLS_FALLING;
          end else begin
            res_cls_d = ptr_pkg::CLS_STABLE;
          end
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rate_d  = res_rate_q;
          out_cls_d   = res_cls_q;
          out_held_d  = fill_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      fill_q      <= '0;
      thr_q       <= ptr_pkg::ThrReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    idx_q      <= idx_d;
    t0_q       <= t0_d;
    x_q        <= x_d;
    y_q        <= y_d;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    sxy_q      <= sxy_d;
    sxx_q      <= sxx_d;
    tmp_q      <= tmp_d;
    den_q      <= den_d;
    neg_q      <= neg_d;
    res_rate_q <= res_rate_d;
    res_cls_q  <= res_cls_d;
    out_rate_q <= out_rate_d;
    out_cls_q  <= out_cls_d;
    out_held_q <= out_held_d;
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.rate_pa_per_hour = out_rate_q;
  assign out_o.trend_class      = out_cls_q;
  assign out_o.samples_held     = ptr_pkg::HeldW'(out_held_q);

`ifndef SYNTHESIS
  // The shared unit is never left running while the block waits for an item.
  a_idle_alu_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !alu_rsp.busy)
    else $error("shared unit busy in idle state");

  // An accepted item always leaves at least one sample in the ring.
  a_fill_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (fill_q != '0))
    else $error("fill level zero after accepting an item");

  // An unknown class is only reported while fewer than two samples are held.
  a_unknown_few: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.trend_class == ptr_pkg::CLS_UNKNOWN))
      |-> (out_o.samples_held < ptr_pkg::HeldW'(2)))
    else $error("unknown class with two or more samples");

  // A rising class always comes with a positive rate.
  a_rising_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.trend_class == ptr_pkg::CLS_RISING))
      |-> (out_o.rate_pa_per_hour > 0))
    else $error("rising class with non-positive rate");
`endif

endmodule
